/* rtl/core/adsr_pkg.sv */
// Shared types and constants for the ADSR envelope level pipeline.
package adsr_pkg;

    localparam int LVL_W    = 16;
    localparam int DUR_W    = 24;
    localparam int PH_BITS  = 31;
    localparam int QUO_W    = 32;
    localparam int NUM_W    = DUR_W + PH_BITS;
    localparam int MULT_W   = DUR_W + LVL_W;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [LVL_W-1:0] FULL_LEVEL = 16'h8000;

    localparam logic [DUR_W-1:0] RST_ATTACK  = 24'd480;
    localparam logic [DUR_W-1:0] RST_DECAY   = 24'd4800;
    localparam logic [LVL_W-1:0] RST_SUSTAIN = 16'd22938;
    localparam logic [DUR_W-1:0] RST_RELEASE = 24'd9600;

    typedef enum logic [2:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_SUSTAIN = 3'd2,
        REG_RELEASE = 3'd3,
        REG_CURVE   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [DUR_W-1:0] attack;
        logic [DUR_W-1:0] decay;
        logic [LVL_W-1:0] sustain;
        logic [DUR_W-1:0] rel_ticks;
        logic             quad;
    } t_cfg;

    // How the divider quotient turns into a level at the end of the pipe.
    typedef struct packed {
        logic             quad;
        logic             zero;
        logic             add;
        logic [LVL_W-1:0] base;
        logic [LVL_W-1:0] mul;
    } t_side;

    typedef struct packed {
        logic [DUR_W-1:0] rem;
        logic [QUO_W-1:0] work;
        logic [DUR_W-1:0] den;
        t_side            side;
    } t_div;

endpackage

/* rtl/core/adsr_front.sv */
// Front stages: phase decode and divider operand setup.
module adsr_front #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [TIME_BITS-1:0] i_start,
    input  logic [TIME_BITS-1:0] i_stop,
    input  logic [TIME_BITS-1:0] i_now,
    input  adsr_pkg::t_cfg       i_cfg,
    output logic                 o_valid,
    output adsr_pkg::t_div       o_div
);

    localparam int CW = (TIME_BITS > adsr_pkg::DUR_W) ? TIME_BITS : adsr_pkg::DUR_W;

    logic                 r_v1, r_v2, r_v3;
    logic [TIME_BITS-1:0] r_start1, r_stop1, r_now1;
    logic                 r_before2, r_held2;
    logic [TIME_BITS-1:0] r_t2, r_r2;
    logic [adsr_pkg::DUR_W-1:0] r_x3, r_len3;
    adsr_pkg::t_side      r_side3;
    adsr_pkg::t_div       r_div4;
    logic                 r_v4;

    logic                 n_before, n_held;
    logic [TIME_BITS-1:0] n_t, n_r;
    logic [CW-1:0]        w_t, w_r, w_d;
    logic [adsr_pkg::LVL_W-1:0] w_sus, w_gap;
    logic [adsr_pkg::DUR_W-1:0] n_x, n_len;
    adsr_pkg::t_side      n_side;
    logic [adsr_pkg::MULT_W-1:0] w_prod;
    logic [adsr_pkg::DUR_W-1:0]  w_rest;
    logic [adsr_pkg::NUM_W-1:0]  w_num;
    adsr_pkg::t_div       n_div;

    // Stage 2: ordering of the ticks
    always_comb begin
        n_before = r_now1 < r_start1;
        n_held   = (r_stop1 == '0) || (r_stop1 > r_now1);
        n_t      = r_now1 - r_start1;
        n_r      = r_now1 - r_stop1;
    end

    // Stage 3: pick the phase
    always_comb begin
        w_t   = CW'(r_t2);
        w_r   = CW'(r_r2);
        w_d   = w_t - CW'(i_cfg.attack);
        w_sus = (i_cfg.sustain > adsr_pkg::FULL_LEVEL) ? adsr_pkg::FULL_LEVEL : i_cfg.sustain;
        w_gap = adsr_pkg::FULL_LEVEL - w_sus;
        n_x         = '0;
        n_len       = adsr_pkg::DUR_W'(1);
        n_side.quad = i_cfg.quad;
        n_side.zero = 1'b1;
        n_side.add  = 1'b1;
        n_side.base = '0;
        n_side.mul  = '0;
        priority if (r_before2) begin
            n_side.base = '0;
        end else if (r_held2) begin
            if (w_t < CW'(i_cfg.attack)) begin
                // Squared attack rises with t, so hand L-t to the (L-x) dividend
                n_x         = i_cfg.quad ? (i_cfg.attack - adsr_pkg::DUR_W'(w_t))
                                         : adsr_pkg::DUR_W'(w_t);
                n_len       = i_cfg.attack;
                n_side.zero = 1'b0;
                n_side.mul  = adsr_pkg::FULL_LEVEL;
            end else if (w_d < CW'(i_cfg.decay)) begin
                n_x         = adsr_pkg::DUR_W'(w_d);
                n_len       = i_cfg.decay;
                n_side.zero = 1'b0;
                n_side.mul  = w_gap;
                n_side.add  = i_cfg.quad;
                n_side.base = i_cfg.quad ? w_sus : adsr_pkg::FULL_LEVEL;
            end else begin
                n_side.base = w_sus;
            end
        end else begin
            if (w_r < CW'(i_cfg.rel_ticks)) begin
                n_x         = adsr_pkg::DUR_W'(w_r);
                n_len       = i_cfg.rel_ticks;
                n_side.zero = 1'b0;
                n_side.mul  = w_sus;
                n_side.add  = i_cfg.quad;
                n_side.base = i_cfg.quad ? '0 : w_sus;
            end
        end
    end

    // Stage 4: dividend is x*M for linear ramps, (L-x)<<31 for squared ones
    always_comb begin
        w_prod = adsr_pkg::MULT_W'(r_x3) * adsr_pkg::MULT_W'(r_side3.mul);
        w_rest = r_len3 - r_x3;
        w_num  = r_side3.quad ? (adsr_pkg::NUM_W'(w_rest) << adsr_pkg::PH_BITS)
                              : adsr_pkg::NUM_W'(w_prod);
        n_div.rem  = adsr_pkg::DUR_W'(w_num[adsr_pkg::NUM_W-1:adsr_pkg::QUO_W]);
        n_div.work = w_num[adsr_pkg::QUO_W-1:0];
        n_div.den  = r_len3;
        n_div.side = r_side3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        r_start1  <= i_start;
        r_stop1   <= i_stop;
        r_now1    <= i_now;
        r_before2 <= n_before;
        r_held2   <= n_held;
        r_t2      <= n_t;
        r_r2      <= n_r;
        r_x3      <= n_x;
        r_len3    <= n_len;
        r_side3   <= n_side;
        r_div4    <= n_div;
    end

    assign o_valid = r_v4;
    assign o_div   = r_div4;

endmodule

/* rtl/core/adsr_div_step.sv */
// One restoring-division step: one quotient bit per stage.
module adsr_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  adsr_pkg::t_div i_div,
    output logic           o_valid,
    output adsr_pkg::t_div o_div
);

    logic [adsr_pkg::DUR_W:0] w_trial;
    logic                     w_ge;
    adsr_pkg::t_div           n_div;
    adsr_pkg::t_div           r_div;
    logic                     r_valid;

    always_comb begin
        w_trial    = {i_div.rem, i_div.work[adsr_pkg::QUO_W-1]};
        w_ge       = w_trial >= {1'b0, i_div.den};
        n_div      = i_div;
        n_div.rem  = w_ge ? adsr_pkg::DUR_W'(w_trial - {1'b0, i_div.den})
                          : w_trial[adsr_pkg::DUR_W-1:0];
        n_div.work = {i_div.work[adsr_pkg::QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_div <= n_div;
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

/* rtl/core/adsr_post.sv */
// Back stages: square the phase fraction, scale, and form the level.
module adsr_post (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [adsr_pkg::QUO_W-1:0] i_quo,
    input  adsr_pkg::t_side            i_side,
    output logic                       o_valid,
    output logic [adsr_pkg::LVL_W-1:0] o_level
);

    localparam int SQ_W = 2 * adsr_pkg::QUO_W;
    localparam int G_W  = SQ_W - adsr_pkg::PH_BITS;
    localparam int SC_W = G_W + adsr_pkg::LVL_W;

    logic                       r_v1, r_v2, r_v3;
    logic [adsr_pkg::QUO_W-1:0] r_q1;
    logic [SQ_W-1:0]            r_sq1;
    adsr_pkg::t_side            r_side1, r_side2;
    logic [adsr_pkg::LVL_W-1:0] r_p2, n_p, r_level3;

    logic [G_W-1:0]             w_g;
    logic [SC_W-1:0]            w_scaled;

    always_comb begin
        w_g      = r_sq1[SQ_W-1:adsr_pkg::PH_BITS];
        w_scaled = SC_W'(w_g) * SC_W'(r_side1.mul);
        if (r_side1.zero) begin
            n_p = '0;
        end else if (r_side1.quad) begin
            n_p = adsr_pkg::LVL_W'(w_scaled >> adsr_pkg::PH_BITS);
        end else begin
            n_p = adsr_pkg::LVL_W'(r_q1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_q1     <= i_quo;
        r_sq1    <= SQ_W'(i_quo) * SQ_W'(i_quo);
        r_side1  <= i_side;
        r_p2     <= n_p;
        r_side2  <= r_side1;
        r_level3 <= r_side2.add ? (r_side2.base + r_p2) : (r_side2.base - r_p2);
    end

    assign o_valid = r_v3;
    assign o_level = r_level3;

endmodule

/* rtl/core/adsr_envelope_level_top.sv */
// Top level of the pipelined ADSR envelope level generator.
//
// Use: pulse start with i_note_start, i_note_stop and i_now_tick; the item is
// taken at any clock edge where start is high and busy is low. busy stays low,
// so a new item can be issued every cycle, one level per voice per sample.
// Each item yields exactly one result: o_done is high for one cycle with
// o_level (unsigned Q1.15) valid in that same cycle. The receiver cannot hold
// results off, and nothing here ever needs it to.
// Pipeline: 4 decode stages, 32 divider stages at one quotient bit each,
// and 3 stages for squaring, scaling and the final add. Throughput: one
// item per cycle, set by the fully pipelined divider.
// Configuration: APB-style port, registers at byte address 4*i (attack,
// decay, sustain, release, curve mode). Write only while no item is in
// flight. pready is always high; reads return the current register value.
// Reset (synchronous, active low): drop all items in flight and load the
// default ramp lengths, sustain level and linear curve.
module adsr_envelope_level_top #(
    parameter int TIME_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [TIME_BITS-1:0]          i_note_start,
    input  logic [TIME_BITS-1:0]          i_note_stop,
    input  logic [TIME_BITS-1:0]          i_now_tick,
    output logic                          o_done,
    output logic [adsr_pkg::LVL_W-1:0]    o_level,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adsr_pkg::ADDR_W-1:0]   paddr,
    input  logic [adsr_pkg::DATA_W-1:0]   pwdata,
    output logic [adsr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int LAT = 4 + adsr_pkg::QUO_W + 3;

    adsr_pkg::t_cfg   r_cfg;
    adsr_pkg::t_reg_idx w_idx;
    logic             w_wr;

    logic             w_valid [0:adsr_pkg::QUO_W];
    adsr_pkg::t_div   w_div   [0:adsr_pkg::QUO_W];

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign w_idx  = adsr_pkg::t_reg_idx'(paddr[adsr_pkg::ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // Register file: write on the access phase, ignore unmapped indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack    <= adsr_pkg::RST_ATTACK;
            r_cfg.decay     <= adsr_pkg::RST_DECAY;
            r_cfg.sustain   <= adsr_pkg::RST_SUSTAIN;
            r_cfg.rel_ticks <= adsr_pkg::RST_RELEASE;
            r_cfg.quad      <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                adsr_pkg::REG_ATTACK:  r_cfg.attack    <= pwdata[adsr_pkg::DUR_W-1:0];
                adsr_pkg::REG_DECAY:   r_cfg.decay     <= pwdata[adsr_pkg::DUR_W-1:0];
                adsr_pkg::REG_SUSTAIN: r_cfg.sustain   <= pwdata[adsr_pkg::LVL_W-1:0];
                adsr_pkg::REG_RELEASE: r_cfg.rel_ticks <= pwdata[adsr_pkg::DUR_W-1:0];
                adsr_pkg::REG_CURVE:   r_cfg.quad      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::DATA_W'(r_cfg.attack);
            adsr_pkg::REG_DECAY:   prdata = adsr_pkg::DATA_W'(r_cfg.decay);
            adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::DATA_W'(r_cfg.sustain);
            adsr_pkg::REG_RELEASE: prdata = adsr_pkg::DATA_W'(r_cfg.rel_ticks);
            adsr_pkg::REG_CURVE:   prdata = adsr_pkg::DATA_W'(r_cfg.quad);
            default:               prdata = '0;
        endcase
    end

    // Decode the phase and set up the dividend and divisor
    adsr_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_start (i_note_start),
        .i_stop  (i_note_stop),
        .i_now   (i_now_tick),
        .i_cfg   (r_cfg),
        .o_valid (w_valid[0]),
        .o_div   (w_div[0])
    );

    // Divider: one quotient bit per stage, MSB first
    for (genvar g = 0; g < adsr_pkg::QUO_W; g++) begin : g_div
        adsr_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_div   (w_div[g]),
            .o_valid (w_valid[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    // Square for quadratic ramps, scale, and add to or subtract from the phase base level
    adsr_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[adsr_pkg::QUO_W]),
        .i_quo   (w_div[adsr_pkg::QUO_W].work),
        .i_side  (w_div[adsr_pkg::QUO_W].side),
        .o_valid (o_done),
        .o_level (o_level)
    );

`ifndef SYNTHESIS
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("item accepted but no result after pipeline latency");

    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result produced without a matching item");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_level <= adsr_pkg::FULL_LEVEL))
        else $error("level above full scale");
`endif

endmodule
